// File: hdl/naes_pkg.sv
// Shared types and command codes for the nearest alive entry search block.
`default_nettype none

package naes_pkg;

  // Command codes as they arrive on the command port.
  localparam logic [1:0] CMD_CLEAR  = 2'd0;
  localparam logic [1:0] CMD_INSERT = 2'd1;
  localparam logic [1:0] CMD_QUERY  = 2'd2;

  // Width of the fixed request and result fields.
  localparam int ID_BITS     = 16;
  localparam int FIELD_BITS  = 16;
  localparam int RADIUS2_BITS = 2 * FIELD_BITS;

  // Classified request kind, produced by the front part.
  typedef enum logic [1:0] {
    K_CLEAR,
    K_INSERT,
    K_QUERY,
    K_NOP
  } kind_t;

  // Back part sequencer states.
  typedef enum logic [1:0] {
    B_IDLE,
    B_SCAN,
    B_FINISH
  } back_state_t;

  // One classified request as it travels from the front to the back part.
  typedef struct packed {
    kind_t                         kind;
    logic [ID_BITS-1:0]            entry_id;
    logic signed [FIELD_BITS-1:0]  pos_x;
    logic signed [FIELD_BITS-1:0]  pos_y;
    logic                          is_alive;
    logic [RADIUS2_BITS-1:0]       radius2;
  } cmd_t;

  // One result item.
  typedef struct packed {
    logic               found;
    logic [ID_BITS-1:0] nearest_id;
    logic               table_full;
  } res_t;

endpackage

`default_nettype wire

// File: hdl/naes_front.sv
// Front part: takes requests, classifies the command and squares the radius.
`default_nettype none

module naes_front #(
  parameter int POS_BITS = 16
) (
  input  wire                                   clk,
  input  wire                                   rst,
  input  wire                                   push,
  output logic                                  full,
  input  wire [1:0]                             command,
  input  wire [naes_pkg::ID_BITS-1:0]           entry_id,
  input  wire signed [naes_pkg::FIELD_BITS-1:0] pos_x,
  input  wire signed [naes_pkg::FIELD_BITS-1:0] pos_y,
  input  wire                                   is_alive,
  input  wire [naes_pkg::FIELD_BITS-1:0]        max_distance,
  output logic                                  out_valid,
  input  wire                                   out_ready,
  output naes_pkg::cmd_t                        out_cmd
);

  localparam int EXT = naes_pkg::FIELD_BITS - POS_BITS;

  logic                 valid;
  logic                 valid_next;
  logic                 accept;
  naes_pkg::kind_t      kind_dec;
  naes_pkg::cmd_t       cmd_dec;

  assign full      = valid && !out_ready;
  assign accept    = push && !full;
  assign out_valid = valid;

  always_comb begin
    unique case (command)
      naes_pkg::CMD_CLEAR:  kind_dec = naes_pkg::K_CLEAR;
      naes_pkg::CMD_INSERT: kind_dec = naes_pkg::K_INSERT;
      naes_pkg::CMD_QUERY:  kind_dec = naes_pkg::K_QUERY;
      default:              kind_dec = naes_pkg::K_NOP;
    endcase
  end

  // Coordinates keep their low POS_BITS bits, read as two's complement.
  always_comb begin
    cmd_dec.kind     = kind_dec;
    cmd_dec.entry_id = entry_id;
    cmd_dec.pos_x    = (pos_x <<< EXT) >>> EXT;
    cmd_dec.pos_y    = (pos_y <<< EXT) >>> EXT;
    cmd_dec.is_alive = is_alive;
    cmd_dec.radius2  = naes_pkg::RADIUS2_BITS'(max_distance)
                     * naes_pkg::RADIUS2_BITS'(max_distance);
  end

  always_comb begin
    if (accept) begin
      valid_next = 1'b1;
    end else if (out_ready) begin
      valid_next = 1'b0;
    end else begin
      valid_next = valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_cmd <= cmd_dec;
    end
  end

endmodule

`default_nettype wire

// File: hdl/naes_fifo.sv
// Small first-in first-out queue used between the block's parts.
`default_nettype none

module naes_fifo #(
  parameter int  DEPTH  = 2,
  parameter type data_t = logic
) (
  input  wire   clk,
  input  wire   rst,
  input  wire   push,
  output logic  full,
  input  data_t wdata,
  input  wire   pop,
  output logic  empty,
  output data_t rdata
);

  localparam int PW = $clog2(DEPTH);
  localparam int NW = $clog2(DEPTH + 1);

  data_t          slots [DEPTH];
  logic [PW-1:0]  wr_ptr;
  logic [PW-1:0]  rd_ptr;
  logic [NW-1:0]  fill;
  logic           do_push;
  logic           do_pop;

  assign full    = (fill == NW'(DEPTH));
  assign empty   = (fill == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= wdata;
    end
  end

endmodule

`default_nettype wire

// File: hdl/naes_back.sv
// Back part: entry table memory, scan sequencer and distance pipeline.
`default_nettype none

module naes_back #(
  parameter int TABLE_DEPTH = 64,
  parameter int POS_BITS    = 16
) (
  input  wire              clk,
  input  wire              rst,
  input  wire              cmd_empty,
  output logic             cmd_pop,
  input  naes_pkg::cmd_t   cmd_in,
  input  wire              res_full,
  output logic             res_push,
  output naes_pkg::res_t   res_out
);

  localparam int AW   = $clog2(TABLE_DEPTH);
  localparam int CW   = $clog2(TABLE_DEPTH + 1);
  localparam int IDW  = naes_pkg::ID_BITS;
  localparam int WW   = IDW + 2 * POS_BITS + 1;
  localparam int SQW  = 2 * POS_BITS;
  localparam int D2W  = SQW + 1;
  localparam int CMPW = naes_pkg::RADIUS2_BITS + 1;

  // Word layout: alive, y, x, id from the top bit down.
  localparam int X_LO = IDW;
  localparam int Y_LO = IDW + POS_BITS;
  localparam int A_BIT = IDW + 2 * POS_BITS;

  naes_pkg::back_state_t state;
  naes_pkg::back_state_t state_next;
  naes_pkg::cmd_t        cur;

  logic [WW-1:0]  entry_mem [TABLE_DEPTH];
  logic [WW-1:0]  rd_data;
  logic [CW-1:0]  count;
  logic [CW-1:0]  issue_ptr;
  logic           issue;
  logic           wr_en;
  logic [AW-1:0]  wr_addr;
  logic [WW-1:0]  wr_word;

  logic           hit_found;
  logic [AW-1:0]  hit_idx;

  logic                 s1_valid;
  logic [AW-1:0]        s1_addr;
  logic                 s2_valid;
  logic [IDW-1:0]       s2_id;
  logic [POS_BITS-1:0]  s2_dx;
  logic [POS_BITS-1:0]  s2_dy;
  logic                 s3_valid;
  logic [IDW-1:0]       s3_id;
  logic [SQW-1:0]       s3_dxx;
  logic [SQW-1:0]       s3_dyy;
  logic                 s4_valid;
  logic [IDW-1:0]       s4_id;
  logic [D2W-1:0]       s4_d2;

  logic                 best_found;
  logic [D2W-1:0]       best_d2;
  logic [IDW-1:0]       best_id;

  logic [IDW-1:0]       rd_id;
  logic [POS_BITS-1:0]  rd_x;
  logic [POS_BITS-1:0]  rd_y;
  logic                 rd_alive;
  logic [POS_BITS:0]    diff_x;
  logic [POS_BITS:0]    diff_y;
  logic [POS_BITS:0]    abs_x;
  logic [POS_BITS:0]    abs_y;
  logic                 pipe_busy;
  logic                 in_range;
  logic                 better;
  logic                 room;

  assign rd_id    = rd_data[IDW-1:0];
  assign rd_x     = rd_data[X_LO +: POS_BITS];
  assign rd_y     = rd_data[Y_LO +: POS_BITS];
  assign rd_alive = rd_data[A_BIT];

  // Signed differences one bit wider than a coordinate; the magnitude always
  // fits POS_BITS bits, so no entry is ever out of reach for being too far.
  assign diff_x = {rd_x[POS_BITS-1], rd_x}
                - {cur.pos_x[POS_BITS-1], cur.pos_x[POS_BITS-1:0]};
  assign diff_y = {rd_y[POS_BITS-1], rd_y}
                - {cur.pos_y[POS_BITS-1], cur.pos_y[POS_BITS-1:0]};
  assign abs_x  = diff_x[POS_BITS] ? -diff_x : diff_x;
  assign abs_y  = diff_y[POS_BITS] ? -diff_y : diff_y;

  assign pipe_busy = s1_valid || s2_valid || s3_valid || s4_valid;
  assign room      = (count < CW'(TABLE_DEPTH));

  assign in_range = (CMPW'(s4_d2) <= CMPW'(cur.radius2));
  assign better   = !best_found || (s4_d2 < best_d2)
                 || ((s4_d2 == best_d2) && (s4_id > best_id));

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      naes_pkg::B_IDLE: begin
        if (!cmd_empty) begin
          if (cmd_in.kind == naes_pkg::K_INSERT || cmd_in.kind == naes_pkg::K_QUERY) begin
            state_next = naes_pkg::B_SCAN;
          end else begin
            state_next = naes_pkg::B_FINISH;
          end
        end
      end
      naes_pkg::B_SCAN: begin
        if (!issue && !pipe_busy) begin
          state_next = naes_pkg::B_FINISH;
        end
      end
      naes_pkg::B_FINISH: begin
        if (!res_full) begin
          state_next = naes_pkg::B_IDLE;
        end
      end
      default: state_next = naes_pkg::B_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    cmd_pop  = 1'b0;
    res_push = 1'b0;
    issue    = 1'b0;
    unique case (state)
      naes_pkg::B_IDLE:   cmd_pop  = !cmd_empty;
      naes_pkg::B_SCAN:   issue    = (issue_ptr < count);
      naes_pkg::B_FINISH: res_push = !res_full;
      default: ;
    endcase
  end

  always_comb begin
    res_out.found      = (cur.kind == naes_pkg::K_QUERY) && best_found;
    res_out.nearest_id = res_out.found ? best_id : '0;
    res_out.table_full = (cur.kind == naes_pkg::K_INSERT) && !hit_found && !room;
  end

  assign wr_en   = res_push && (cur.kind == naes_pkg::K_INSERT) && (hit_found || room);
  assign wr_addr = hit_found ? hit_idx : count[AW-1:0];
  assign wr_word = {cur.is_alive, cur.pos_y[POS_BITS-1:0], cur.pos_x[POS_BITS-1:0],
                    cur.entry_id};

  always_ff @(posedge clk) begin
    if (wr_en) begin
      entry_mem[wr_addr] <= wr_word;
    end
    if (issue) begin
      rd_data <= entry_mem[issue_ptr[AW-1:0]];
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= naes_pkg::B_IDLE;
      count      <= '0;
      issue_ptr  <= '0;
      hit_found  <= 1'b0;
      best_found <= 1'b0;
      s1_valid   <= 1'b0;
      s2_valid   <= 1'b0;
      s3_valid   <= 1'b0;
      s4_valid   <= 1'b0;
    end else begin
      state    <= state_next;
      s1_valid <= issue;
      s2_valid <= s1_valid && rd_alive && (cur.kind == naes_pkg::K_QUERY);
      s3_valid <= s2_valid;
      s4_valid <= s3_valid;
      if (cmd_pop) begin
        issue_ptr  <= '0;
        hit_found  <= 1'b0;
        best_found <= 1'b0;
      end else begin
        if (issue) begin
          issue_ptr <= issue_ptr + 1'b1;
        end
        if (s1_valid && (cur.kind == naes_pkg::K_INSERT) && !hit_found
            && (rd_id == cur.entry_id)) begin
          hit_found <= 1'b1;
        end
        if (s4_valid && in_range && better) begin
          best_found <= 1'b1;
        end
      end
      if (res_push) begin
        if (cur.kind == naes_pkg::K_CLEAR) begin
          count <= '0;
        end else if (cur.kind == naes_pkg::K_INSERT && !hit_found && room) begin
          count <= count + 1'b1;
        end
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      cur <= cmd_in;
    end
    if (s1_valid && !hit_found && (rd_id == cur.entry_id)) begin
      hit_idx <= s1_addr;
    end
    if (issue) begin
      s1_addr <= issue_ptr[AW-1:0];
    end
    s2_id  <= rd_id;
    s2_dx  <= abs_x[POS_BITS-1:0];
    s2_dy  <= abs_y[POS_BITS-1:0];
    s3_id  <= s2_id;
    s3_dxx <= SQW'(s2_dx) * SQW'(s2_dx);
    s3_dyy <= SQW'(s2_dy) * SQW'(s2_dy);
    s4_id  <= s3_id;
    s4_d2  <= D2W'(s3_dxx) + D2W'(s3_dyy);
    if (s4_valid && in_range && better) begin
      best_d2 <= s4_d2;
      best_id <= s4_id;
    end
  end

  a_count_bounded: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(TABLE_DEPTH))
    else $error("entry count beyond table depth");

  a_issue_within_fill: assert property (@(posedge clk) disable iff (rst)
    issue_ptr <= count)
    else $error("scan pointer passed the filled part of the table");

  a_full_only_when_filled: assert property (@(posedge clk) disable iff (rst)
    (res_push && res_out.table_full) |-> (count == CW'(TABLE_DEPTH)))
    else $error("table reported full while room remains");

  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    (res_push && cur.kind == naes_pkg::K_CLEAR) |=> (count == '0))
    else $error("clear did not empty the table");

  a_scan_pipe_idle: assert property (@(posedge clk) disable iff (rst)
    (state == naes_pkg::B_IDLE) |-> !(s2_valid || s3_valid || s4_valid))
    else $error("distance pipeline busy outside a scan");

endmodule

`default_nettype wire

// File: hdl/nearest_alive_entry_search_top.sv
// Top level of the nearest alive entry search block.
//
// The block keeps a table of up to TABLE_DEPTH entries, each holding a 16-bit
// id, an x,y position and an alive flag, and serves three kinds of request:
// clear the table, insert or overwrite an entry by id, and find the nearest
// alive entry within a radius of a query point (boundary included, ties won
// by the higher id). Both sides behave as queues: a request is taken on a
// clock edge with push high and full low, and the oldest result sits on the
// result ports while empty is low and leaves on an edge with pop high. Every
// request gives exactly one result. An insert or a query reads each filled
// table slot once through the single read port of the entry memory, so its
// time in the back part grows with the number of filled slots. Requests are
// taken while the back part works, up to a front register and a two-deep
// request queue, and up to two results wait in an output queue. Slots fill
// from the bottom and are freed only by a clear, so a fill count stands for
// the valid bits and reset needs no pass over the memory. Distances are
// compared exactly as dx*dx + dy*dy against the squared radius; coordinates
// keep their low min(COORD_BITS, 16) bits as two's complement numbers.
`default_nettype none

module nearest_alive_entry_search_top #(
  parameter int TABLE_DEPTH = 64,
  parameter int COORD_BITS  = 16
) (
  input  wire                                   clk,
  input  wire                                   rst,
  input  wire                                   push,
  output logic                                  full,
  input  wire [1:0]                             command,
  input  wire [naes_pkg::ID_BITS-1:0]           entry_id,
  input  wire signed [naes_pkg::FIELD_BITS-1:0] pos_x,
  input  wire signed [naes_pkg::FIELD_BITS-1:0] pos_y,
  input  wire                                   is_alive,
  input  wire [naes_pkg::FIELD_BITS-1:0]        max_distance,
  output logic                                  empty,
  input  wire                                   pop,
  output logic                                  found,
  output logic [naes_pkg::ID_BITS-1:0]          nearest_id,
  output logic                                  table_full
);

  // Stored coordinate width: the request fields carry at most 16 bits.
  localparam int POS_BITS = (COORD_BITS < naes_pkg::FIELD_BITS) ? COORD_BITS
                                                                 : naes_pkg::FIELD_BITS;

  logic            front_valid;
  logic            cmdq_full;
  naes_pkg::cmd_t  front_cmd;
  logic            cmdq_empty;
  logic            cmdq_pop;
  naes_pkg::cmd_t  cmdq_head;
  logic            resq_full;
  logic            resq_push;
  naes_pkg::res_t  back_res;
  naes_pkg::res_t  resq_head;

  // Front part: takes requests, classifies them and squares the radius.
  naes_front #(
    .POS_BITS (POS_BITS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .command      (command),
    .entry_id     (entry_id),
    .pos_x        (pos_x),
    .pos_y        (pos_y),
    .is_alive     (is_alive),
    .max_distance (max_distance),
    .out_valid    (front_valid),
    .out_ready    (!cmdq_full),
    .out_cmd      (front_cmd)
  );

  // Request queue that lets the front and the back part stall apart.
  naes_fifo #(
    .DEPTH  (2),
    .data_t (naes_pkg::cmd_t)
  ) u_cmd_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (front_valid),
    .full  (cmdq_full),
    .wdata (front_cmd),
    .pop   (cmdq_pop),
    .empty (cmdq_empty),
    .rdata (cmdq_head)
  );

  // Back part: table memory, scan sequencer and distance pipeline.
  naes_back #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .POS_BITS    (POS_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_empty (cmdq_empty),
    .cmd_pop   (cmdq_pop),
    .cmd_in    (cmdq_head),
    .res_full  (resq_full),
    .res_push  (resq_push),
    .res_out   (back_res)
  );

  // Result queue: a finished result waits here while new work goes on.
  naes_fifo #(
    .DEPTH  (2),
    .data_t (naes_pkg::res_t)
  ) u_res_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (resq_push),
    .full  (resq_full),
    .wdata (back_res),
    .pop   (pop),
    .empty (empty),
    .rdata (resq_head)
  );

  assign found      = resq_head.found;
  assign nearest_id = resq_head.nearest_id;
  assign table_full = resq_head.table_full;

endmodule

`default_nettype wire
